@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rvm_pkg.sv @@
package rvm_pkg;

    localparam int REG_COUNT_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CODE_DEPTH_DEF = 65536;

    localparam int CMD_W    = 4;
    localparam int RIDX_W   = 6;
    localparam int IMM_W    = 32;
    localparam int IP_W     = 16;
    localparam int CSIZE_W  = 17;
    localparam int FAULT_W  = 2;

    localparam logic [CMD_W-1:0] OP_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] OP_SUB  = 4'd1;
    localparam logic [CMD_W-1:0] OP_MUL  = 4'd2;
    localparam logic [CMD_W-1:0] OP_DIV  = 4'd3;
    localparam logic [CMD_W-1:0] OP_CMP  = 4'd4;
    localparam logic [CMD_W-1:0] OP_MOV  = 4'd5;
    localparam logic [CMD_W-1:0] OP_JMP  = 4'd6;
    localparam logic [CMD_W-1:0] OP_LD   = 4'd7;
    localparam logic [CMD_W-1:0] OP_IN   = 4'd8;
    localparam logic [CMD_W-1:0] OP_OUT  = 4'd9;
    localparam logic [CMD_W-1:0] OP_HALT = 4'd10;

    localparam logic [RIDX_W-1:0] JC_ALWAYS = 6'd0;
    localparam logic [RIDX_W-1:0] JC_Z      = 6'd1;
    localparam logic [RIDX_W-1:0] JC_NZ     = 6'd2;
    localparam logic [RIDX_W-1:0] JC_POS    = 6'd3;
    localparam logic [RIDX_W-1:0] JC_NEG    = 6'd4;
    localparam logic [RIDX_W-1:0] JC_NNEG   = 6'd5;
    localparam logic [RIDX_W-1:0] JC_NPOS   = 6'd6;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_ACC   = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    localparam logic [FAULT_W-1:0] FLT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FLT_ACC  = 2'd1;
    localparam logic [FAULT_W-1:0] FLT_DIV  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, start register read
        logic exec;      // operands valid, compute step
        logic div_start;
        logic commit;    // write back and form result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_div;
        logic div_done;
    } t_stat;

endpackage

@@ design/rvm_div.sv @@
module rvm_div #(
    parameter int DATA_WIDTH = rvm_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quot,
    output logic [DATA_WIDTH-1:0] o_rem
);
    import rvm_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_q, r_d, r_rem;
    logic                  r_qneg, r_rneg, r_busy;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH:0]   w_sh, w_sub;
    logic                  r_done;

    assign w_sh  = {r_rem, r_q[DATA_WIDTH-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DATA_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num[DATA_WIDTH-1] ? -i_num : i_num;
            r_d    <= i_den[DATA_WIDTH-1] ? -i_den : i_den;
            r_rem  <= '0;
            r_qneg <= i_num[DATA_WIDTH-1] ^ i_den[DATA_WIDTH-1];
            r_rneg <= i_num[DATA_WIDTH-1];
        end else if (r_busy) begin
            if (!w_sub[DATA_WIDTH]) begin
                r_rem <= w_sub[DATA_WIDTH-1:0];
                r_q   <= {r_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DATA_WIDTH-1:0];
                r_q   <= {r_q[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    // done is registered and raised in the cycle after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_busy && (r_cnt == CW'(1));
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? -r_q : r_q;
    assign o_rem  = r_rneg ? -r_rem : r_rem;

    `ASSERT_IMPL(a_div_nostart_busy, i_clk, i_rst_n, r_busy, !i_start,
        "divider restarted while busy")
endmodule

@@ design/rvm_ctrl.sv @@
module rvm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    input  rvm_pkg::t_stat i_stat,
    output rvm_pkg::t_cmd  o_cmd
);
    import rvm_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EXEC = 6'b000100,
        S_DIVW = 6'b001000,
        S_CMT  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVW;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_CMT;
                end
            end
            S_DIVW: begin
                if (i_stat.div_done) n_state = S_CMT;
            end
            S_CMT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);

    `ASSERT_NEXT(a_cmt_to_out, i_clk, i_rst_n, o_cmd.commit, o_res_valid,
        "result not presented after commit")
    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_res_valid, !o_req_ready,
        "request accepted while result pending")
endmodule

@@ design/rvm_dp.sv @@
module rvm_dp #(
    parameter int REG_COUNT  = rvm_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rvm_pkg::DATA_WIDTH_DEF,
    parameter int CODE_DEPTH = rvm_pkg::CODE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rvm_pkg::t_cmd                 i_cmd,
    output rvm_pkg::t_stat                o_stat,
    input  logic [rvm_pkg::CMD_W-1:0]     i_op,
    input  logic [rvm_pkg::RIDX_W-1:0]    i_dst,
    input  logic [rvm_pkg::RIDX_W-1:0]    i_src,
    input  logic [rvm_pkg::IMM_W-1:0]     i_imm,
    input  logic [rvm_pkg::IMM_W-1:0]     i_inv,
    input  logic                          i_cfg_we,
    input  logic [rvm_pkg::CSIZE_W-1:0]   i_cfg_data,
    output logic [rvm_pkg::IP_W-1:0]      o_next_ip,
    output logic                          o_out_valid,
    output logic [rvm_pkg::IMM_W-1:0]     o_out_value,
    output logic                          o_in_taken,
    output logic                          o_halted,
    output logic [rvm_pkg::FAULT_W-1:0]   o_fault
);
    import rvm_pkg::*;
    `include "assert_macros.svh"

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DW = DATA_WIDTH;
    localparam int AW = IP_W + 2;   // signed address arithmetic

    logic [DW-1:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;

    logic [CMD_W-1:0]  r_op;
    logic [RIDX_W-1:0] r_cond;
    logic [RW-1:0]     r_d, r_s;
    logic [IMM_W-1:0]  r_imm, r_inv;
    logic [DW-1:0]     r_a, r_b, r_res;
    logic              r_zf, r_pf, r_nf;
    logic [IP_W-1:0]   r_ip;
    logic [1:0]        r_stop;
    logic [CSIZE_W-1:0] r_csize;
    logic              r_ov, r_it;
    logic [IMM_W-1:0]  r_ovv;

    // register number wraps modulo REG_COUNT; small constant table
    function automatic logic [RW-1:0] ridx(input logic [RIDX_W-1:0] r);
        logic [RW-1:0] v;
        v = '0;
        for (int k = 0; k < (1 << RIDX_W); k++)
            if (r == RIDX_W'(k)) v = RW'(k % REG_COUNT);
        return v;
    endfunction

    logic [CSIZE_W-1:0] w_lim;
    assign w_lim = (r_csize < CSIZE_W'(CODE_DEPTH)) ? r_csize : CSIZE_W'(CODE_DEPTH);

    // register file read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_cond <= i_dst;
            r_d    <= ridx(i_dst);
            r_s    <= ridx(i_src);
            r_imm  <= i_imm;
            r_inv  <= i_inv;
        end
        r_a <= r_vld[r_d] ? r_rf[r_d] : '0;
        r_b <= r_vld[r_s] ? r_rf[r_s] : '0;
    end

    // divider
    logic w_ddone;
    logic [DW-1:0] w_q, w_r;
    logic w_dstart;
    logic w_bz, w_m1;
    assign w_bz = (r_b == '0);
    assign w_m1 = (r_b == '1);
    assign w_dstart = i_cmd.div_start && !w_bz && !w_m1;

    rvm_div #(.DATA_WIDTH(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_ddone),
        .o_quot  (w_q),
        .o_rem   (w_r)
    );

    logic r_fast;   // divide resolved without the iterative unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fast <= 1'b0;
        else          r_fast <= i_cmd.div_start && (w_bz || w_m1);
    end

    logic w_ipok;
    assign w_ipok = (CSIZE_W'(r_ip) < w_lim);
    assign o_stat.is_div   = (r_op == OP_DIV) && (r_stop == ST_RUN) && w_ipok;
    assign o_stat.div_done = w_ddone || r_fast;

    logic signed [DW-1:0] w_sa, w_sb;
    assign w_sa = r_a;
    assign w_sb = r_b;

    // execute and commit
    logic         w_taken;
    logic signed [AW-1:0] w_tgt;
    logic signed [IMM_W:0] w_off;
    always_comb begin
        case (r_cond)
            JC_ALWAYS: w_taken = 1'b1;
            JC_Z:      w_taken = r_zf;
            JC_NZ:     w_taken = !r_zf;
            JC_POS:    w_taken = r_pf;
            JC_NEG:    w_taken = r_nf;
            JC_NNEG:   w_taken = r_pf || r_zf;
            JC_NPOS:   w_taken = r_nf || r_zf;
            default:   w_taken = 1'b0;
        endcase
    end

    logic signed [IMM_W+1:0] w_t32;
    assign w_off = {r_imm[IMM_W-1], r_imm};
    always_comb begin
        if (r_op == OP_JMP && w_taken)
            w_t32 = $signed({2'b00, r_ip}) + (IMM_W+2)'(w_off);
        else
            w_t32 = $signed((IMM_W+2)'({2'b00, r_ip})) + 1;
    end
    assign w_tgt = AW'(w_t32);
    logic w_tgt_bad;
    assign w_tgt_bad = w_t32[IMM_W+1] ||
                       ((IMM_W+2)'(w_t32) >= (IMM_W+2)'({1'b0, w_lim}));

    logic [DW-1:0] w_mul;
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_op)
                OP_ADD:  r_res <= r_a + r_b;
                OP_SUB:  r_res <= r_a - r_b;
                OP_MUL:  r_res <= w_mul;
                OP_MOV:  r_res <= r_b;
                OP_LD:   r_res <= DW'($signed(r_imm));
                OP_IN:   r_res <= DW'($signed(r_inv));
                default: r_res <= r_res;
            endcase
        end
    end
    assign w_mul = DW'(r_a * r_b);

    logic [DW-1:0] w_qf, w_rf;
    always_comb begin
        if (w_m1) begin
            w_qf = -r_a;
            w_rf = '0;
        end else begin
            w_qf = w_q;
            w_rf = w_r;
        end
    end

    logic w_run;
    assign w_run = (r_stop == ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_zf    <= 1'b0;
            r_pf    <= 1'b0;
            r_nf    <= 1'b0;
            r_ip    <= '0;
            r_stop  <= ST_RUN;
            r_csize <= CSIZE_W'(65536);
            r_ov    <= 1'b0;
            r_it    <= 1'b0;
            r_ovv   <= '0;
        end else begin
            if (i_cfg_we) r_csize <= i_cfg_data;
            if (i_cmd.commit) begin
                r_ov  <= 1'b0;
                r_it  <= 1'b0;
                r_ovv <= '0;
                if (w_run && !w_ipok) begin
                    r_stop <= ST_ACC;
                end else if (w_run) begin
                    case (r_op)
                        OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_LD, OP_IN: begin
                            r_rf[r_d]  <= r_res;
                            r_vld[r_d] <= 1'b1;
                            r_it       <= (r_op == OP_IN);
                        end
                        OP_DIV: begin
                            if (!w_bz) begin
                                r_rf[r_s]  <= w_rf;
                                r_vld[r_s] <= 1'b1;
                                r_rf[r_d]  <= w_qf;
                                r_vld[r_d] <= 1'b1;
                            end
                        end
                        OP_CMP: begin
                            r_zf <= (w_sa == w_sb);
                            r_nf <= (w_sa < w_sb);
                            r_pf <= (w_sa > w_sb);
                        end
                        OP_OUT: begin
                            r_ov  <= 1'b1;
                            r_ovv <= IMM_W'(r_a);
                        end
                        default: ;
                    endcase
                    if (r_op == OP_HALT)                r_stop <= ST_HALT;
                    else if (r_op == OP_DIV && w_bz)    r_stop <= ST_DIVZ;
                    else if (w_tgt_bad)                 r_stop <= ST_ACC;
                    else                                r_ip   <= IP_W'(w_tgt);
                end
            end
        end
    end

    assign o_next_ip   = r_ip;
    assign o_out_valid = r_ov;
    assign o_out_value = r_ovv;
    assign o_in_taken  = r_it;
    assign o_halted    = (r_stop != ST_RUN);
    always_comb begin
        case (r_stop)
            ST_ACC:  o_fault = FLT_ACC;
            ST_DIVZ: o_fault = FLT_DIV;
            default: o_fault = FLT_NONE;
        endcase
    end

    `ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stop != ST_RUN, r_stop == $past(r_stop),
        "stop state changed while frozen")
    `ASSERT_IMPL(a_ov_only_out, i_clk, i_rst_n, !r_ov, r_ovv == '0,
        "out value nonzero without out")
endmodule

@@ design/register_vm_execute_step.sv @@
// Register machine execute step.
// Input channel (s_axis_*): one instruction per request; tdata packs cmd,
// dest_reg, src_reg, immediate and in_value from bit 0 upward.
// Output channel (m_axis_*): one result per request; tdata packs next_ip,
// out_valid, out_value, in_taken, halted, fault from bit 0 upward.
// Configuration channel (i_cfg_*): writes code_size; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Most operations pass through the read, execute and commit states before
// the result is valid; a divide with a general divisor runs a restoring
// divider, one quotient bit a cycle, while the controller waits for it.
// One request is in flight at a time; the next is taken once the result
// has been taken. Reset clears registers, flags, the instruction pointer
// and the stop state, and sets code_size to 65536.
// When the receiver stalls the result holds steady and no request is taken.
// After halt or a fault every request reports the frozen state.
module register_vm_execute_step #(
    parameter int REG_COUNT  = rvm_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rvm_pkg::DATA_WIDTH_DEF,
    parameter int CODE_DEPTH = rvm_pkg::CODE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[3:0], dest_reg[9:4], src_reg[15:10], immediate[47:16], in_value[79:48]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_ip[15:0], out_valid[16], out_value[48:17], in_taken[49], halted[50],
    // fault[52:51]
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [16:0]  i_cfg_data
);
    import rvm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    logic [IP_W-1:0]    w_nip;
    logic               w_ov, w_it, w_h;
    logic [IMM_W-1:0]   w_ovv;
    logic [FAULT_W-1:0] w_f;

    assign o_cfg_ready = 1'b1;

    rvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rvm_dp #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH),
        .CODE_DEPTH (CODE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (s_axis_tdata[3:0]),
        .i_dst       (s_axis_tdata[9:4]),
        .i_src       (s_axis_tdata[15:10]),
        .i_imm       (s_axis_tdata[47:16]),
        .i_inv       (s_axis_tdata[79:48]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_next_ip   (w_nip),
        .o_out_valid (w_ov),
        .o_out_value (w_ovv),
        .o_in_taken  (w_it),
        .o_halted    (w_h),
        .o_fault     (w_f)
    );

    assign m_axis_tdata = {3'b000, w_f, w_h, w_it, w_ovv, w_ov, w_nip};
endmodule
